// ===== sv/wdsu_pkg.sv =====
// Types and constants for the word divide unit.
// No dependencies; imported by word_divide_signed_unsigned_core.
`timescale 1ns / 1ps
`default_nettype none

package wdsu_pkg;

  localparam int unsigned W = 32;

  localparam logic [W-1:0] MIN_NEG  = 32'h8000_0000;
  localparam logic [W-1:0] MAX_POS  = 32'h7fff_ffff;
  localparam logic [W-1:0] ALL_ONES = 32'hffff_ffff;

  localparam logic [3:0] CR_LT = 4'b1000;
  localparam logic [3:0] CR_GT = 4'b0100;
  localparam logic [3:0] CR_EQ = 4'b0010;

  typedef enum logic [0:0] {
    CMD_DIVW  = 1'b0,
    CMD_DIVWU = 1'b1
  } wdsu_cmd_e;

  typedef struct packed {
    wdsu_cmd_e    command;
    logic [W-1:0] dividend;
    logic [W-1:0] divisor;
    logic [4:0]   dest_reg;
    logic         record;
    logic         overflow_enable;
    logic         sticky_in;
  } wdsu_in_t;

  typedef struct packed {
    logic [4:0]   dest_index;
    logic [W-1:0] quotient;
    logic         flags_write;
    logic         overflow_out;
    logic         sticky_out;
    logic         cond_write;
    logic [3:0]   cond_field;
  } wdsu_out_t;

  typedef struct packed {
    logic [4:0]   dest_reg;
    logic         record;
    logic         overflow_enable;
    logic         sticky_in;
    logic         negate;
    logic         special;
    logic [W-1:0] special_q;
  } wdsu_side_t;

endpackage

`default_nettype wire

// ===== sv/word_divide_signed_unsigned_core.sv =====
// Pipelined 32-bit signed/unsigned word divide, one quotient bit per stage.
// Depends on wdsu_pkg for the word types and constants.
//
//  channel | direction | handshake             | word
//  in      | input     | in_valid_i/in_stall_o  | wdsu_pkg::wdsu_in_t
//  out     | output    | out_valid_o/out_stall_i| wdsu_pkg::wdsu_out_t
//
// One word per cycle sustained while the output is not stalled.
// The pipeline is the 32 restoring-divide stages plus a sign/operand stage
// and the output register. A stalled output freezes every stage at once; a
// skid register takes one word during a stall, so in_stall_o is registered.
// Reset clears the valid bits only, the skid valid bit among them.
`timescale 1ns / 1ps
`default_nettype none

module word_divide_signed_unsigned_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire wdsu_pkg::wdsu_in_t  in_data_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      wdsu_pkg::wdsu_out_t out_data_o
);
  import wdsu_pkg::*;

  localparam int unsigned NSTG = W;

  logic       advance;
  logic       skid_vld_q;
  wdsu_in_t   skid_q;
  logic       src_vld;
  wdsu_in_t   src;

  logic         vld_q  [0:NSTG];
  logic [W-1:0] rem_q  [0:NSTG];
  logic [W-1:0] nq_q   [0:NSTG];
  logic [W-1:0] den_q  [0:NSTG];
  wdsu_side_t   side_q [0:NSTG];

  logic [W-1:0] rem_d [1:NSTG];
  logic [W-1:0] nq_d  [1:NSTG];

  logic [W-1:0] mag_a, mag_b;
  wdsu_side_t   side0;
  logic         is_signed;

  logic         out_vld_q;
  wdsu_out_t    out_q;
  wdsu_out_t    out_d;
  logic [W-1:0] q_fix;
  logic         ovf;
  logic         so_new;

  assign advance    = !(out_vld_q && out_stall_i);
  assign in_stall_o = skid_vld_q;
  assign src_vld    = skid_vld_q || in_valid_i;
  assign src        = skid_vld_q ? skid_q : in_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else if (advance) begin
      skid_vld_q <= 1'b0;
    end else if (in_valid_i && !skid_vld_q) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!advance && in_valid_i && !skid_vld_q) begin
      skid_q <= in_data_i;
    end
  end

  // Operand stage: magnitudes and the fixed-result cases.
  always_comb begin
    is_signed = (src.command == CMD_DIVW);
    mag_a = (is_signed && src.dividend[W-1]) ? W'(-src.dividend) : src.dividend;
    mag_b = (is_signed && src.divisor[W-1])  ? W'(-src.divisor)  : src.divisor;
    side0.dest_reg        = src.dest_reg;
    side0.record          = src.record;
    side0.overflow_enable = src.overflow_enable;
    side0.sticky_in       = src.sticky_in;
    side0.negate          = is_signed && (src.dividend[W-1] ^ src.divisor[W-1]);
    side0.special         = 1'b0;
    side0.special_q       = MAX_POS;
    if (src.divisor == '0) begin
      side0.special = 1'b1;
      if (!is_signed) begin
        side0.special_q = ALL_ONES;
      end else if (src.dividend[W-1]) begin
        side0.special_q = MIN_NEG;
      end
    end else if (is_signed && src.dividend == MIN_NEG && src.divisor == ALL_ONES) begin
      side0.special = 1'b1;
    end
  end

  // One restoring step per stage.
  always_comb begin
    logic [W:0] trial;
    logic [W:0] diff;
    for (int k = 0; k < NSTG; k++) begin
      trial = {rem_q[k], nq_q[k][W-1]};
      diff  = trial - {1'b0, den_q[k]};
      rem_d[k+1] = diff[W] ? trial[W-1:0] : diff[W-1:0];
      nq_d[k+1]  = {nq_q[k][W-2:0], !diff[W]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= NSTG; k++) begin
        vld_q[k] <= 1'b0;
      end
      out_vld_q <= 1'b0;
    end else if (advance) begin
      vld_q[0] <= src_vld;
      for (int k = 1; k <= NSTG; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
      out_vld_q <= vld_q[NSTG];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rem_q[0]  <= '0;
      nq_q[0]   <= mag_a;
      den_q[0]  <= mag_b;
      side_q[0] <= side0;
      for (int k = 1; k <= NSTG; k++) begin
        rem_q[k]  <= rem_d[k];
        nq_q[k]   <= nq_d[k];
        den_q[k]  <= den_q[k-1];
        side_q[k] <= side_q[k-1];
      end
      out_q <= out_d;
    end
  end

  // Sign fix, overrides and flags.
  always_comb begin
    q_fix = side_q[NSTG].negate ? W'(-nq_q[NSTG]) : nq_q[NSTG];
    if (side_q[NSTG].special) begin
      q_fix = side_q[NSTG].special_q;
    end
    ovf    = side_q[NSTG].special;
    so_new = side_q[NSTG].sticky_in || (side_q[NSTG].overflow_enable && ovf);
    out_d.dest_index   = side_q[NSTG].dest_reg;
    out_d.quotient     = q_fix;
    out_d.flags_write  = side_q[NSTG].overflow_enable;
    out_d.overflow_out = side_q[NSTG].overflow_enable && ovf;
    out_d.sticky_out   = so_new;
    out_d.cond_write   = side_q[NSTG].record;
    out_d.cond_field   = '0;
    if (side_q[NSTG].record) begin
      if (q_fix == '0) begin
        out_d.cond_field = CR_EQ;
      end else if (q_fix[W-1]) begin
        out_d.cond_field = CR_LT;
      end else begin
        out_d.cond_field = CR_GT;
      end
      out_d.cond_field[0] = so_new;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_skid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q && !advance |=> skid_vld_q)
    else $error("skid word dropped while pipeline frozen");

  a_cond_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.cond_write |-> out_data_o.cond_field == 4'b0000)
    else $error("condition field set without record");

  a_cond_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.cond_write |-> $onehot(out_data_o.cond_field[3:1]))
    else $error("condition field not one-hot");

  a_ovf_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.overflow_out |->
      (out_data_o.quotient == MAX_POS || out_data_o.quotient == MIN_NEG ||
       out_data_o.quotient == ALL_ONES))
    else $error("overflow with non-fixed quotient");

  a_ovf_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.overflow_out |-> out_data_o.flags_write &&
      out_data_o.sticky_out)
    else $error("overflow reported without flag update");

endmodule

`default_nettype wire

// ===== sim/wdsu_quotient_check.sv =====
// Watches both channels of word_divide_signed_unsigned_core, predicts each
// quotient word and compares it with what the block returns. Depends on wdsu_pkg.
`timescale 1ns / 1ps

module wdsu_quotient_check (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  wdsu_pkg::wdsu_in_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  wdsu_pkg::wdsu_out_t out_data_i,
  output int                 mismatches_o,
  output int                 words_owed_o
);
  import wdsu_pkg::*;

  wdsu_out_t owed_words[$];

  function automatic wdsu_out_t predict_divide(input wdsu_in_t w);
    logic [W-1:0] num_mag;
    logic [W-1:0] den_mag;
    logic [W-1:0] q;
    logic         ovf;
    logic         so;
    wdsu_out_t    r;
    ovf = 1'b0;
    if (w.divisor == '0) begin
      ovf = 1'b1;
      if (w.command == CMD_DIVWU) q = ALL_ONES;
      else q = w.dividend[W-1] ? MIN_NEG : MAX_POS;
    end else if (w.command == CMD_DIVWU) begin
      q = w.dividend / w.divisor;
    end else if (w.dividend == MIN_NEG && w.divisor == ALL_ONES) begin
      ovf = 1'b1;
      q = MAX_POS;
    end else begin
      num_mag = w.dividend[W-1] ? (~w.dividend + 1'b1) : w.dividend;
      den_mag = w.divisor[W-1] ? (~w.divisor + 1'b1) : w.divisor;
      q = num_mag / den_mag;
      if (w.dividend[W-1] ^ w.divisor[W-1]) q = ~q + 1'b1;
    end
    so = w.sticky_in | (w.overflow_enable & ovf);
    r.dest_index   = w.dest_reg;
    r.quotient     = q;
    r.flags_write  = w.overflow_enable;
    r.overflow_out = w.overflow_enable & ovf;
    r.sticky_out   = so;
    r.cond_write   = w.record;
    r.cond_field   = '0;
    if (w.record) begin
      if (q == '0) r.cond_field = CR_EQ;
      else if (q[W-1]) r.cond_field = CR_LT;
      else r.cond_field = CR_GT;
      r.cond_field[0] = so;
    end
    return r;
  endfunction

  initial begin
    mismatches_o = 0;
    words_owed_o = 0;
  end

  always @(posedge clk_i) begin
    wdsu_out_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) owed_words.push_back(predict_divide(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (owed_words.size() == 0) begin
          mismatches_o <= mismatches_o + 1;
          if (mismatches_o < 10) $display("unexpected word: %p", out_data_i);
        end else begin
          want = owed_words.pop_front();
          if (out_data_i.dest_index !== want.dest_index ||
              out_data_i.quotient !== want.quotient ||
              out_data_i.flags_write !== want.flags_write ||
              out_data_i.overflow_out !== want.overflow_out ||
              out_data_i.sticky_out !== want.sticky_out ||
              out_data_i.cond_write !== want.cond_write ||
              out_data_i.cond_field !== want.cond_field) begin
            mismatches_o <= mismatches_o + 1;
            if (mismatches_o < 10)
              $display("mismatch at %0t: expected %p, got %p", $realtime, want, out_data_i);
          end
        end
      end
    end
    words_owed_o <= owed_words.size();
  end

endmodule

// ===== sim/word_divide_signed_unsigned_core_test.sv =====
// Drives divide words into word_divide_signed_unsigned_core with random idling
// on both sides; wdsu_quotient_check predicts and compares. Depends on wdsu_pkg.
`timescale 1ns / 1ps

module word_divide_signed_unsigned_core_test;
  import wdsu_pkg::*;

  localparam int RANDOM_WORDS = 1400;
  localparam int CYCLE_LIMIT  = 200000;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  wdsu_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  wdsu_out_t out_data_o;
  logic      steady;
  int        mismatches;
  int        words_owed;
  int        cycle_count = 0;

  word_divide_signed_unsigned_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  wdsu_quotient_check check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .mismatches_o(mismatches),
    .words_owed_o(words_owed)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("word_divide_signed_unsigned_core regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) out_stall_i <= !steady && ($urandom_range(99) < 18);

  function automatic wdsu_in_t divide_word(input wdsu_cmd_e cmd, input logic [W-1:0] a,
                                           input logic [W-1:0] b, input logic [4:0] rt,
                                           input logic [2:0] flags);
    wdsu_in_t w;
    w.command         = cmd;
    w.dividend        = a;
    w.divisor         = b;
    w.dest_reg        = rt;
    w.record          = flags[2];
    w.overflow_enable = flags[1];
    w.sticky_in       = flags[0];
    return w;
  endfunction

  function automatic logic [W-1:0] pick_operand(input logic as_divisor);
    logic [W-1:0] v;
    case ($urandom_range(9))
      0: v = as_divisor ? '0 : MIN_NEG;
      1: v = ALL_ONES;
      2: v = as_divisor ? 32'd1 : MAX_POS;
      3: v = $urandom_range(40);
      4: v = -$urandom_range(40);
      5: v = $urandom >> $urandom_range(31);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_word(input wdsu_in_t w);
    if (!steady && $urandom_range(99) < 18) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    steady      = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // extremes, zero divisors and signed overflow
    send_word(divide_word(CMD_DIVW,  32'd100,  32'd7,    5'd0,  3'b111));
    send_word(divide_word(CMD_DIVW,  -32'd100, 32'd7,    5'd31, 3'b110));
    send_word(divide_word(CMD_DIVW,  32'd100,  -32'd7,   5'd1,  3'b100));
    send_word(divide_word(CMD_DIVW,  -32'd100, -32'd7,   5'd2,  3'b101));
    send_word(divide_word(CMD_DIVW,  32'd5,    '0,       5'd3,  3'b110));
    send_word(divide_word(CMD_DIVW,  -32'd5,   '0,       5'd4,  3'b111));
    send_word(divide_word(CMD_DIVW,  '0,       '0,       5'd5,  3'b100));
    send_word(divide_word(CMD_DIVW,  MIN_NEG,  ALL_ONES, 5'd6,  3'b110));
    send_word(divide_word(CMD_DIVW,  MIN_NEG,  ALL_ONES, 5'd7,  3'b000));
    send_word(divide_word(CMD_DIVW,  MIN_NEG,  32'd1,    5'd8,  3'b100));
    send_word(divide_word(CMD_DIVW,  MAX_POS,  ALL_ONES, 5'd9,  3'b100));
    send_word(divide_word(CMD_DIVW,  32'd3,    32'd9,    5'd10, 3'b101));
    send_word(divide_word(CMD_DIVW,  MIN_NEG,  MIN_NEG,  5'd11, 3'b100));
    send_word(divide_word(CMD_DIVWU, ALL_ONES, 32'd1,    5'd12, 3'b100));
    send_word(divide_word(CMD_DIVWU, ALL_ONES, ALL_ONES, 5'd13, 3'b111));
    send_word(divide_word(CMD_DIVWU, 32'd7,    '0,       5'd14, 3'b110));
    send_word(divide_word(CMD_DIVWU, MIN_NEG,  ALL_ONES, 5'd15, 3'b110));
    send_word(divide_word(CMD_DIVWU, '0,       '0,       5'd16, 3'b001));
    send_word(divide_word(CMD_DIVWU, MIN_NEG,  32'd2,    5'd17, 3'b100));
    send_word(divide_word(CMD_DIVWU, 32'd1,    ALL_ONES, 5'd18, 3'b010));

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      steady = (n >= 500 && n < 850);
      send_word(divide_word(wdsu_cmd_e'($urandom_range(1)), pick_operand(1'b0),
                            pick_operand(1'b1), 5'($urandom), 3'($urandom)));
    end
    steady = 1'b0;
    in_valid_i <= 1'b0;

    while (words_owed != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("word_divide_signed_unsigned_core regression: pass");
    end else begin
      $display("word_divide_signed_unsigned_core regression: fail");
    end
    $finish;
  end

endmodule
